FILE: rtl/core/rsm_pkg.sv
// Shared widths and defaults for the running set median block.
`timescale 1ns / 1ps
package rsm_pkg;
    localparam int DATA_W           = 32;
    localparam int SET_COUNT_W      = 5;
    localparam int MAX_VALUES_DEF   = 16;
endpackage

FILE: rtl/core/rsm_cell.sv
// One cell of the sorted insertion chain: holds one value, shifts up on insert.
`timescale 1ns / 1ps
module rsm_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 5
) (
    input  logic                              clk,
    input  logic                              insert_en,
    input  logic [CW-1:0]                     fill,
    input  logic signed [rsm_pkg::DATA_W-1:0] sample,
    input  logic signed [rsm_pkg::DATA_W-1:0] left_val,
    input  logic                              left_gt,
    output logic signed [rsm_pkg::DATA_W-1:0] val,
    output logic                              gt
);
    import rsm_pkg::*;

    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;
    logic                     occupied;

    always_comb
    begin
        occupied = fill > CW'(INDEX);
        gt       = !occupied || (val_reg > sample);
        val_next = val_reg;
        if (insert_en && gt)
        begin
            val_next = left_gt ? left_val : sample;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
endmodule

FILE: rtl/core/running_set_median.sv
// Top level: sorted insertion chain with median pick, add and output register.
// out_valid rises after the PICK and SUM states that follow the transfer of a marked last value.
// Throughput: one value per cycle inside a set; after each last value the input
// stalls through pick and average, longer while an earlier result is held.
// Reset: clears fill count, drop flag, control state and output valid;
// stored values are not cleared and are never read before being written.
`timescale 1ns / 1ps
module running_set_median #(
    parameter int MAX_VALUES = rsm_pkg::MAX_VALUES_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [rsm_pkg::DATA_W-1:0]      sample,
    input  logic                                   last_sample,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [rsm_pkg::DATA_W-1:0]      median_value,
    output logic [rsm_pkg::SET_COUNT_W-1:0]        set_count,
    output logic                                   dropped_flag
);
    import rsm_pkg::*;

    localparam int CW = $clog2(MAX_VALUES + 1);
    localparam int IW = $clog2(MAX_VALUES);

    typedef enum logic [2:0] {
        S_COLLECT = 3'b001,
        S_PICK    = 3'b010,
        S_SUM     = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            fill_reg, fill_next;
    logic                     ovf_reg, ovf_next;
    logic signed [DATA_W-1:0] lo_reg, hi_reg;
    logic [CW-1:0]            cnt_reg;
    logic                     drop_reg;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] median_reg;
    logic [SET_COUNT_W-1:0]   count_out_reg;
    logic                     drop_out_reg;

    logic                     in_xfer;
    logic                     full;
    logic                     insert_en;
    logic                     out_load;
    logic [CW-1:0]            lo_pos, hi_pos;
    logic [IW-1:0]            lo_idx, hi_idx;
    logic signed [DATA_W:0]   pair_sum;
    logic [CW+SET_COUNT_W-1:0] cnt_ext;

    logic signed [DATA_W-1:0] cell_val [MAX_VALUES];
    logic                     cell_gt  [MAX_VALUES];

    assign in_stall  = (state_reg != S_COLLECT);
    assign in_xfer   = in_valid && !in_stall;
    assign full      = (fill_reg == CW'(MAX_VALUES));
    assign insert_en = in_xfer && !full;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_VALUES; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                rsm_cell #(.INDEX(gi), .CW(CW)) u_cell (
                    .clk       (clk),
                    .insert_en (insert_en),
                    .fill      (fill_reg),
                    .sample    (sample),
                    .left_val  (sample),
                    .left_gt   (1'b0),
                    .val       (cell_val[gi]),
                    .gt        (cell_gt[gi])
                );
            end
            else
            begin : g_body
                rsm_cell #(.INDEX(gi), .CW(CW)) u_cell (
                    .clk       (clk),
                    .insert_en (insert_en),
                    .fill      (fill_reg),
                    .sample    (sample),
                    .left_val  (cell_val[gi-1]),
                    .left_gt   (cell_gt[gi-1]),
                    .val       (cell_val[gi]),
                    .gt        (cell_gt[gi])
                );
            end
        end
    endgenerate

    assign lo_pos   = (fill_reg - CW'(1)) >> 1;
    assign hi_pos   = fill_reg >> 1;
    assign lo_idx   = lo_pos[IW-1:0];
    assign hi_idx   = hi_pos[IW-1:0];
    assign pair_sum = {lo_reg[DATA_W-1], lo_reg} + {hi_reg[DATA_W-1], hi_reg};
    assign cnt_ext  = {{SET_COUNT_W{1'b0}}, cnt_reg};
    assign out_load = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_COLLECT:
            begin
                if (in_xfer)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                    if (last_sample)
                    begin
                        state_next = S_PICK;
                    end
                end
            end
            S_PICK:
            begin
                fill_next  = '0;
                ovf_next   = 1'b0;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_COLLECT;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_COLLECT;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PICK)
        begin
            lo_reg   <= cell_val[lo_idx];
            hi_reg   <= cell_val[hi_idx];
            cnt_reg  <= fill_reg;
            drop_reg <= ovf_reg;
        end
        if ((state_reg == S_SUM) && out_load)
        begin
            median_reg    <= pair_sum[DATA_W:1];
            count_out_reg <= cnt_ext[SET_COUNT_W-1:0];
            drop_out_reg  <= drop_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign median_value = median_reg;
    assign set_count    = count_out_reg;
    assign dropped_flag = drop_out_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(MAX_VALUES))
        else $error("fill count beyond store depth");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && last_sample) |=> ##1 (fill_reg == '0 && !ovf_reg))
        else $error("store not emptied after last transfer");

    a_result_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM && out_load) |=> out_valid)
        else $error("result not presented after sum");

    generate
        for (gi = 0; gi < MAX_VALUES - 1; gi++)
        begin : g_chk
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                (fill_reg > CW'(gi + 1)) |-> (cell_val[gi] <= cell_val[gi+1]))
                else $error("chain out of order");
        end
    endgenerate
endmodule
